[src/sleep_timer_sorted_queue_macros.svh]
// Assertion macros shared by the sorted timer queue checks.
`ifndef SLEEP_TIMER_SORTED_QUEUE_MACROS_SVH
`define SLEEP_TIMER_SORTED_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STSQ_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sorted timer queue check failed");

// Check that a condition in one cycle implies another in the next cycle.
`define STSQ_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted timer queue sequence check failed");

`endif

[src/stsq_pkg.sv]
// Shared types and constants of the sorted timer queue.
package stsq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int ID_W            = 6;
    localparam int TIMER_W         = 32;
    localparam int ELAPSED_W       = 20;
    localparam int KIND_W          = 2;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic signed [TIMER_W-1:0] TIMER_MIN = {1'b1, {(TIMER_W-1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef struct packed {
        logic                        action;
        logic [ID_W-1:0]             entry_id;
        logic signed [TIMER_W-1:0]   start_timer;
        logic [ELAPSED_W-1:0]        elapsed;
    } t_in_item;

    typedef struct packed {
        t_kind                       kind;
        logic [ID_W-1:0]             id;
        logic signed [TIMER_W-1:0]   timer;
        logic                        last;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]             id;
        logic signed [TIMER_W-1:0]   timer;
    } t_entry;

    typedef struct packed {
        logic signed [TIMER_W-1:0]   a;
        logic signed [TIMER_W:0]     b;
    } t_alu_in;

    typedef struct packed {
        logic signed [TIMER_W-1:0]   sat;
        logic                        gt;
        logic                        le0;
    } t_alu_out;

endpackage

[src/stsq_in_if.sv]
// Input channel of the sorted timer queue: insert and advance items.
interface stsq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [stsq_pkg::ID_W-1:0]            entry_id;
    logic signed [stsq_pkg::TIMER_W-1:0]  start_timer;
    logic [stsq_pkg::ELAPSED_W-1:0]       elapsed;

    modport source (
        output valid, action, entry_id, start_timer, elapsed,
        input  ready
    );

    modport sink (
        input  valid, action, entry_id, start_timer, elapsed,
        output ready
    );
endinterface

[src/stsq_out_if.sv]
// Output channel of the sorted timer queue: result items.
interface stsq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [stsq_pkg::KIND_W-1:0]          result_kind;
    logic [stsq_pkg::ID_W-1:0]            out_id;
    logic signed [stsq_pkg::TIMER_W-1:0]  timer_left;
    logic                                 last;

    modport source (
        output valid, result_kind, out_id, timer_left, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, out_id, timer_left, last,
        output ready
    );
endinterface

[src/stsq_alu.sv]
// Shared subtract unit: insert compare and saturating timer decrement.
module stsq_alu (
    input  stsq_pkg::t_alu_in  i_op,
    output stsq_pkg::t_alu_out o_res
);

    logic signed [stsq_pkg::TIMER_W:0]   w_diff;
    logic signed [stsq_pkg::TIMER_W-1:0] w_sat;

    // Subtract at one bit of headroom
    assign w_diff = {i_op.a[stsq_pkg::TIMER_W-1], i_op.a} - i_op.b;

    // Clamp an underflow to the most negative timer
    assign w_sat = (w_diff[stsq_pkg::TIMER_W] && !w_diff[stsq_pkg::TIMER_W-1])
                 ? stsq_pkg::TIMER_MIN : w_diff[stsq_pkg::TIMER_W-1:0];

    assign o_res.sat = w_sat;
    assign o_res.gt  = !w_diff[stsq_pkg::TIMER_W] && (w_diff != '0);
    assign o_res.le0 = w_sat[stsq_pkg::TIMER_W-1] || (w_sat == '0);

endmodule

[src/stsq_ctrl.sv]
// Sequencer and entry memory of the sorted timer queue.
module stsq_ctrl #(
    parameter int QUEUE_DEPTH = stsq_pkg::DEF_QUEUE_DEPTH,
    localparam int OW = $clog2(QUEUE_DEPTH + 1),
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  stsq_pkg::t_in_item i_item,
    input  logic               i_out_free,
    output logic               o_idle,
    output logic               o_res_load,
    output stsq_pkg::t_result  o_res,
    output logic [OW-1:0]      o_occ
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_CMP = 8'b0000_0100,
        S_ADV_RD  = 8'b0000_1000,
        S_ADV_UPD = 8'b0001_0000,
        S_POP_RD  = 8'b0010_0000,
        S_POP_OUT = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [OW-1:0]       r_occ, n_occ;
    logic [AW-1:0]       r_head, n_head;
    logic [OW-1:0]       r_k, n_k;
    logic [OW-1:0]       r_n, n_n;
    logic                r_pref, n_pref;
    stsq_pkg::t_in_item  r_item, n_item;
    stsq_pkg::t_result   r_res, n_res;
    stsq_pkg::t_entry    r_rd;

    stsq_pkg::t_entry    r_mem [QUEUE_DEPTH];

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    stsq_pkg::t_entry    w_wdata;
    logic                w_re;
    logic [AW-1:0]       w_raddr;
    stsq_pkg::t_entry    w_new;
    stsq_pkg::t_result   w_ins_res;
    stsq_pkg::t_alu_in   w_alu_in;
    stsq_pkg::t_alu_out  w_alu_out;
    logic                w_last;

    // Map a queue position to a slot of the circular store
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [OW-1:0] ofs);
        logic [OW:0] sum;
        sum = (OW+1)'(base) + (OW+1)'(ofs);
        if (sum >= (OW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (OW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Feed the shared unit: compare against the new timer or subtract elapsed
    assign w_alu_in.a = r_rd.timer;
    assign w_alu_in.b = (r_item.action == stsq_pkg::ACT_INSERT)
                      ? {r_item.start_timer[stsq_pkg::TIMER_W-1], r_item.start_timer}
                      : (stsq_pkg::TIMER_W+1)'(r_item.elapsed);

    stsq_alu u_alu (
        .i_op  (w_alu_in),
        .o_res (w_alu_out)
    );

    assign w_new.id      = r_item.entry_id;
    assign w_new.timer   = r_item.start_timer;
    assign w_ins_res     = '{kind: stsq_pkg::KIND_INSERTED, id: r_item.entry_id,
                             timer: '0, last: 1'b1};
    assign w_last        = ((r_k + 1'b1) == r_n);

    // Sequence inserts, timer passes and expiry pops
    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_head     = r_head;
        n_k        = r_k;
        n_n        = r_n;
        n_pref     = r_pref;
        n_item     = r_item;
        n_res      = r_res;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = r_rd;
        w_re       = 1'b0;
        w_raddr    = '0;
        o_res_load = 1'b0;
        o_res      = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    n_k    = '0;
                    n_n    = '0;
                    n_pref = 1'b1;
                    if (i_item.action == stsq_pkg::ACT_ADVANCE) begin
                        n_state = S_ADV_RD;
                    end else if (r_occ == OW'(QUEUE_DEPTH)) begin
                        n_res   = '{kind: stsq_pkg::KIND_REJECTED, id: i_item.entry_id,
                                    timer: '0, last: 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_k     = r_occ;
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (r_k == '0) begin
                    w_we    = 1'b1;
                    w_waddr = f_phys(r_head, r_k);
                    w_wdata = w_new;
                    n_occ   = r_occ + 1'b1;
                    n_res   = w_ins_res;
                    n_state = S_EMIT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = f_phys(r_head, r_k - 1'b1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_we    = 1'b1;
                w_waddr = f_phys(r_head, r_k);
                if (w_alu_out.gt) begin
                    // shift the larger entry one place toward the tail
                    w_wdata = r_rd;
                    n_k     = r_k - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    w_wdata = w_new;
                    n_occ   = r_occ + 1'b1;
                    n_res   = w_ins_res;
                    n_state = S_EMIT;
                end
            end
            S_ADV_RD: begin
                if (r_k == r_occ) begin
                    n_k = '0;
                    if (r_n == '0) begin
                        n_res   = '{kind: stsq_pkg::KIND_NONE, id: '0,
                                    timer: '0, last: 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end else begin
                    w_re    = 1'b1;
                    w_raddr = f_phys(r_head, r_k);
                    n_state = S_ADV_UPD;
                end
            end
            S_ADV_UPD: begin
                w_we          = 1'b1;
                w_waddr       = f_phys(r_head, r_k);
                w_wdata.id    = r_rd.id;
                w_wdata.timer = w_alu_out.sat;
                // count the expired run at the head, up to the result cap
                if (r_pref && w_alu_out.le0 && (int'(r_n) < stsq_pkg::MAX_RESULTS)) begin
                    n_n = r_n + 1'b1;
                end else begin
                    n_pref = 1'b0;
                end
                n_k     = r_k + 1'b1;
                n_state = S_ADV_RD;
            end
            S_POP_RD: begin
                w_re    = 1'b1;
                w_raddr = f_phys(r_head, r_k);
                n_state = S_POP_OUT;
            end
            S_POP_OUT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    o_res      = '{kind: stsq_pkg::KIND_EXPIRED, id: r_rd.id,
                                   timer: r_rd.timer, last: w_last};
                    if (w_last) begin
                        n_head  = f_phys(r_head, r_n);
                        n_occ   = r_occ - r_n;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_POP_RD;
                    end
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    o_res      = r_res;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_head  <= '0;
            r_k     <= '0;
            r_n     <= '0;
            r_pref  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_head  <= n_head;
            r_k     <= n_k;
            r_n     <= n_n;
            r_pref  <= n_pref;
        end
    end

    // Hold the item and the pending result
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
    end

    // Write and read the entry store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_occ  = r_occ;

endmodule

[src/sleep_timer_sorted_queue.sv]
// Top level of the sorted timer queue: channels, result register, checks.
//
// Holds up to QUEUE_DEPTH (id, signed timer) entries in ascending timer
// order in a circular store with one read and one write port, used one
// access at a time, worked by one shared subtract unit under a
// sequencer. The input channel is ready only while the sequencer is
// idle. An insert reads the stored entries from the tail, shifts each
// one with a larger timer a place toward the tail and writes the new
// entry after the first with an equal or smaller timer; an insert when
// full is rejected. An advance decrements every stored entry, then
// streams out the expired entries at the head, one result each, or a
// single "none" result. A full output register stalls the sequencer
// when it has a result to give. Results go out through a one-entry
// output register, so a finished result may wait there while the next
// item is taken.
`include "sleep_timer_sorted_queue_macros.svh"

module sleep_timer_sorted_queue #(
    parameter int QUEUE_DEPTH = stsq_pkg::DEF_QUEUE_DEPTH,
    localparam int OW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stsq_in_if.sink    i_in,
    stsq_out_if.source o_out
);

    stsq_pkg::t_in_item w_item;
    stsq_pkg::t_result  w_res;
    stsq_pkg::t_result  r_out;
    logic               r_out_valid;
    logic               w_idle;
    logic               w_res_load;
    logic               w_out_free;
    logic [OW-1:0]      w_occ;

    // Gather the input payload
    assign w_item.action      = i_in.action;
    assign w_item.entry_id    = i_in.entry_id;
    assign w_item.start_timer = i_in.start_timer;
    assign w_item.elapsed     = i_in.elapsed;

    assign i_in.ready = w_idle;
    assign w_out_free = !r_out_valid || o_out.ready;

    stsq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in.valid && i_in.ready),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_res_load (w_res_load),
        .o_res      (w_res),
        .o_occ      (w_occ)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out.kind;
    assign o_out.out_id      = r_out.id;
    assign o_out.timer_left  = r_out.timer;
    assign o_out.last        = r_out.last;

    // Checks
    `STSQ_CHECK(a_occ_bound, w_occ <= OW'(QUEUE_DEPTH))
    `STSQ_CHECK_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready)
    `STSQ_CHECK(a_single_last, r_out_valid && (r_out.kind != stsq_pkg::KIND_EXPIRED) |-> r_out.last)
    `STSQ_CHECK(a_load_when_free, w_res_load |-> w_out_free)

endmodule

[bench/sleep_timer_sorted_queue_test.sv]
// Self-checking bench for the sorted timer queue: scoreboard of expiries, insert replies and none results.
module sleep_timer_sorted_queue_test;

    localparam int DEPTH        = stsq_pkg::DEF_QUEUE_DEPTH;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 200;
    localparam int SETTLE       = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_CAP    = 60;

    localparam int ID_W      = stsq_pkg::ID_W;
    localparam int TIMER_W   = stsq_pkg::TIMER_W;
    localparam int ELAPSED_W = stsq_pkg::ELAPSED_W;

    typedef struct {
        stsq_pkg::t_in_item item;
        bit                 wait_drain;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stsq_in_if  in_ch();
    stsq_out_if out_ch();

    sleep_timer_sorted_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Timer model state
    logic [ID_W-1:0]           model_ids[DEPTH];
    logic signed [TIMER_W-1:0] model_timers[DEPTH];
    int                        model_count = 0;

    t_stim             stim_q[$];
    t_stim             offered;
    stsq_pkg::t_result expected_results[$];

    int stim_total     = 0;
    int items_accepted = 0;
    int n_predicted    = 0;
    int n_checked      = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle rates per phase: receiver idles more, then sender idles more, then none
    function automatic int src_idle_pct();
        if (items_accepted < stim_total / 3) return 36;
        if (items_accepted < 2 * stim_total / 3) return 57;
        return 0;
    endfunction

    function automatic int sink_idle_pct();
        if (items_accepted < stim_total / 3) return 57;
        if (items_accepted < 2 * stim_total / 3) return 36;
        return 0;
    endfunction

    function automatic void add_stim(logic act, logic [ID_W-1:0] id,
                                     logic signed [TIMER_W-1:0] tv,
                                     logic [ELAPSED_W-1:0] el, bit drain = 1'b0);
        t_stim s;
        s.item.action      = act;
        s.item.entry_id    = id;
        s.item.start_timer = tv;
        s.item.elapsed     = el;
        s.wait_drain       = drain;
        stim_q.push_back(s);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("result %0d: %s: got %0h, want %0h", n_checked, what, got, want);
        fail_count++;
    endtask

    // Apply one item to the timer model; queue its results and return how many
    function automatic int predict_timer_queue(stsq_pkg::t_in_item it);
        logic signed [TIMER_W-1:0] tv;
        logic signed [TIMER_W:0]   diff;
        stsq_pkg::t_result         r;
        int                        pos;
        int                        n;
        tv = it.start_timer;
        r.id    = it.entry_id;
        r.timer = '0;
        r.last  = 1'b1;
        if (it.action == stsq_pkg::ACT_INSERT) begin
            if (model_count >= DEPTH) begin
                r.kind = stsq_pkg::KIND_REJECTED;
            end else begin
                // place after every entry with an equal or smaller timer
                pos = 0;
                while (pos < model_count && model_timers[pos] <= tv)
                    pos++;
                for (int i = model_count; i > pos; i--) begin
                    model_ids[i]    = model_ids[i-1];
                    model_timers[i] = model_timers[i-1];
                end
                model_ids[pos]    = it.entry_id;
                model_timers[pos] = tv;
                model_count++;
                r.kind = stsq_pkg::KIND_INSERTED;
            end
            expected_results.push_back(r);
            return 1;
        end
        // subtract elapsed with saturation at the most negative timer
        for (int i = 0; i < model_count; i++) begin
            diff = model_timers[i] - $signed({1'b0, it.elapsed});
            if (diff < stsq_pkg::TIMER_MIN)
                model_timers[i] = stsq_pkg::TIMER_MIN;
            else
                model_timers[i] = diff[TIMER_W-1:0];
        end
        n = 0;
        while (n < model_count && n < stsq_pkg::MAX_RESULTS && model_timers[n] <= 0)
            n++;
        if (n == 0) begin
            r.kind = stsq_pkg::KIND_NONE;
            r.id   = '0;
            expected_results.push_back(r);
            return 1;
        end
        // pop expired heads in queue order
        for (int i = 0; i < n; i++) begin
            r.kind  = stsq_pkg::KIND_EXPIRED;
            r.id    = model_ids[i];
            r.timer = model_timers[i];
            r.last  = (i + 1 == n);
            expected_results.push_back(r);
        end
        for (int i = n; i < model_count; i++) begin
            model_ids[i-n]    = model_ids[i];
            model_timers[i-n] = model_timers[i];
        end
        model_count -= n;
        return n;
    endfunction

    // Driver: predict on accept, then offer the next pending item
    always @(posedge i_clk) begin
        bit hold;
        int made;
        int owed;
        made = 0;
        if (!i_rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.action      <= stsq_pkg::ACT_INSERT;
            in_ch.entry_id    <= '0;
            in_ch.start_timer <= '0;
            in_ch.elapsed     <= '0;
        end else begin
            hold = in_ch.valid && !in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                made = predict_timer_queue(offered.item);
                n_predicted    <= n_predicted + made;
                items_accepted <= items_accepted + 1;
            end
            owed = n_predicted + made - n_checked;
            if (!hold) begin
                if (stim_q.size() > 0 && $urandom_range(99) >= src_idle_pct()
                        && !(stim_q[0].wait_drain && owed != 0)) begin
                    offered = stim_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.action      <= offered.item.action;
                    in_ch.entry_id    <= offered.item.entry_id;
                    in_ch.start_timer <= offered.item.start_timer;
                    in_ch.elapsed     <= offered.item.elapsed;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (items_accepted == HOLD_AT && !hold_done) begin
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct());
        end
    end

    // Monitor: compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        stsq_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, kind", out_ch.result_kind, 0);
            end else begin
                want = expected_results.pop_front();
                if (out_ch.result_kind !== want.kind)
                    report_mismatch("kind", out_ch.result_kind, want.kind);
                if (out_ch.out_id !== want.id)
                    report_mismatch("id", out_ch.out_id, want.id);
                if (out_ch.timer_left !== want.timer)
                    report_mismatch("timer", out_ch.timer_left, want.timer);
                if (out_ch.last !== want.last)
                    report_mismatch("last", out_ch.last, want.last);
            end
            n_checked <= n_checked + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int                        n_random;
        int                        burst;
        int                        ins_pct;
        logic                      act;
        logic signed [TIMER_W-1:0] tv;
        logic [ELAPSED_W-1:0]      el;

        i_rst_n = 1'b0;

        // Directed: empty advance, extremes, ties, full queue, zero and max elapsed
        add_stim(stsq_pkg::ACT_ADVANCE, 6'd0, 32'sd0, 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd0, stsq_pkg::TIMER_MIN, 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd63, 32'sh7fffffff, 20'hfffff);
        add_stim(stsq_pkg::ACT_INSERT, 6'd1, 32'sd0, 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd2, -32'sd1, 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd3, 32'sd1, 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd4, 32'sd500, 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd5, 32'sd500, 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd6, 32'sd500, 20'd0);
        for (int i = 0; i < 8; i++)
            add_stim(stsq_pkg::ACT_INSERT, 6'(7 + i), 32'(1000 + 37 * (i % 3)), 20'd0);
        add_stim(stsq_pkg::ACT_INSERT, 6'd42, 32'sd7, 20'd0);
        add_stim(stsq_pkg::ACT_ADVANCE, 6'd0, 32'sd0, 20'd0);
        add_stim(stsq_pkg::ACT_ADVANCE, 6'd0, 32'sd0, 20'hfffff);
        add_stim(stsq_pkg::ACT_INSERT, 6'd9, stsq_pkg::TIMER_MIN + 32'sd1, 20'd0);
        add_stim(stsq_pkg::ACT_ADVANCE, 6'd0, 32'sd0, 20'hfffff);
        add_stim(stsq_pkg::ACT_ADVANCE, 6'd21, 32'sd0, 20'hfffff);

        // Random: bursts of inserts and advances with varying insert mix
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            burst = $urandom_range(10, 40);
            case ($urandom_range(3))
                0:       ins_pct = 25;
                1:       ins_pct = 50;
                2:       ins_pct = 70;
                default: ins_pct = 90;
            endcase
            for (int k = 0; k < burst && n_random < RANDOM_ITEMS; k++) begin
                act = ($urandom_range(99) < ins_pct) ? stsq_pkg::ACT_INSERT
                                                     : stsq_pkg::ACT_ADVANCE;
                case ($urandom_range(15))
                    0:       tv = {1'b1, 31'($urandom)};
                    1:       tv = 0 - int'($urandom_range(1000));
                    2, 3:    tv = int'($urandom_range(7)) * 100;
                    default: tv = int'($urandom_range(3000));
                endcase
                case ($urandom_range(15))
                    0:       el = 20'($urandom_range(0, 1048575));
                    1:       el = '0;
                    default: el = 20'($urandom_range(1200));
                endcase
                add_stim(act, 6'($urandom_range(63)), tv, el,
                         n_random == 0 || n_random == DRAIN_AT);
                n_random++;
            end
        end
        stim_total = stim_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every result to come back
        do
            @(posedge i_clk);
        while (items_accepted < stim_total || n_checked < n_predicted);
        repeat (SETTLE) @(posedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch("results never seen", 0, expected_results.size());
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[sleep_timer_sorted_queue.f]
+incdir+src
src/stsq_pkg.sv
src/stsq_in_if.sv
src/stsq_out_if.sv
src/stsq_alu.sv
src/stsq_ctrl.sv
src/sleep_timer_sorted_queue.sv
bench/sleep_timer_sorted_queue_test.sv
